// File: design/htb_pkg.sv
// shared types, codes and constants of the huffman tree builder
package htb_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 256;

   localparam int SYMBOL_W = 8;
   localparam int FREQ_W   = 24;
   localparam int WEIGHT_W = 32;
   localparam int REF_W    = 9;
   localparam int INT_W    = 8;

   // item actions
   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_MERGE = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [1:0] STATUS_COMPLETE = 2'd3;

   localparam logic [REF_W-1:0] REF_NONE     = 9'd511;
   localparam logic [INT_W-1:0] INTERNAL_MAX = 8'd255;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [REF_W-1:0]    node;
   } entry_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [REF_W-1:0]    node_ref;
      logic [WEIGHT_W-1:0] node_frequency;
      logic [REF_W-1:0]    left_ref;
      logic [REF_W-1:0]    right_ref;
      logic                last;
   } result_type;

endpackage

// File: design/htb_if.sv
// valid/ready channel interfaces for request and response items
interface htb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] symbol;
   logic [23:0] frequency;

   modport source(output valid, action, symbol, frequency, input ready);
   modport sink(input valid, action, symbol, frequency, output ready);
endinterface

interface htb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [8:0]  node_ref;
   logic [31:0] node_frequency;
   logic [8:0]  left_ref;
   logic [8:0]  right_ref;
   logic        last;

   modport source(output valid, status, node_ref, node_frequency, left_ref, right_ref,
                  last, input ready);
   modport sink(input valid, status, node_ref, node_frequency, left_ref, right_ref,
                last, output ready);
endinterface

// File: design/huffman_tree_builder_core.sv
// huffman tree builder top level: request/response channels around the queue engine
//
// req_chan carries one item per transfer: add a leaf (symbol, frequency), one merge step,
// or clear. every item gives exactly one transfer on rsp_chan with a status, and for a
// successful merge the new internal node, its children and a last flag for the root.
// the queue lives in a ram ordered by frequency, lowest first, with a rotating head so
// that removing the front entries is only a pointer move.
// an add walks from the tail toward the front, moving each entry of equal or greater
// frequency one place back: it is read in S_SHIFT_RD over the single ram read port and
// written in S_SHIFT_CMP. a merge first reads the lone front leaf or the
// front pair, then inserts the new node the same way; full, empty, clear and unused
// actions and a merge refused by the spent node counter go straight to the response,
// a merge on a lone internal root after one ram read. req_chan.ready is high only while
// the engine waits for an item and reset is low.
// reset empties the queue and the node counter at once; no clearing pass is needed since
// only written entries are ever read.
// the response register holds a finished result while rsp_chan is stalled, and the
// engine already takes and works on the next item; it waits only if a second result is
// ready before the first one is taken.
module huffman_tree_builder_core #(
   parameter int QUEUE_DEPTH = htb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   htb_req_if.sink   req_chan,
   htb_rsp_if.source rsp_chan
);

   // result handoff from the engine
   logic                res_valid;
   logic                res_ready;
   htb_pkg::result_type res_data;

   // response output register
   logic                rsp_valid_ff, rsp_valid_in;
   htb_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                load;

   htb_engine #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .res_valid(res_valid),
      .res_data (res_data),
      .res_ready(res_ready)
   );

   // slot is free when empty or when its transfer completes this cycle
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;
   assign load      = res_valid && res_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds its value while stalled, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_data_ff.status;
   assign rsp_chan.node_ref       = rsp_data_ff.node_ref;
   assign rsp_chan.node_frequency = rsp_data_ff.node_frequency;
   assign rsp_chan.left_ref       = rsp_data_ff.left_ref;
   assign rsp_chan.right_ref      = rsp_data_ff.right_ref;
   assign rsp_chan.last           = rsp_data_ff.last;

endmodule

// File: design/htb_ram.sv
// generic single write port ram with registered read
module htb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/htb_engine.sv
// sequencer that keeps the sorted queue in ram and walks it one entry at a time
module htb_engine #(
   parameter int QUEUE_DEPTH = htb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   htb_req_if.sink              req_chan,
   output logic                 res_valid,
   output htb_pkg::result_type  res_data,
   input  logic                 res_ready
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = $bits(htb_pkg::entry_type);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [CW:0]   DEPTH_X = (CW+1)'(QUEUE_DEPTH);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_HEAD      = 3'd1;
   localparam logic [2:0] S_SECOND    = 3'd2;
   localparam logic [2:0] S_SHIFT_RD  = 3'd3;
   localparam logic [2:0] S_SHIFT_CMP = 3'd4;
   localparam logic [2:0] S_DONE      = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [AW-1:0]             head_ff, head_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [htb_pkg::INT_W-1:0] internal_ff, internal_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic                      merge_ff, merge_in;
   htb_pkg::entry_type        ins_ff, ins_in;
   htb_pkg::result_type       res_ff, res_in;

   logic [CW-1:0]             lidx;
   logic [CW:0]               addr_sum;
   logic [AW-1:0]             phys;
   logic                      wr_en;
   logic                      rd_en;
   htb_pkg::entry_type        wr_entry;
   logic [EW-1:0]             ram_rd;
   htb_pkg::entry_type        rd_entry;
   logic [htb_pkg::WEIGHT_W-1:0] sum_w;
   logic                      rd_less;
   logic                      accept;
   logic                      finish;

   assign rd_entry = htb_pkg::entry_type'(ram_rd);
   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && !reset;

   // logical queue position to ram address, one shared adder for all states
   always_comb begin
      case (state_ff)
         S_IDLE:      lidx = '0;
         S_HEAD:      lidx = CW'(1);
         S_SECOND:    lidx = CW'(2);
         S_SHIFT_RD:  lidx = (idx_ff == '0) ? '0 : idx_ff - CW'(1);
         S_SHIFT_CMP: lidx = idx_ff;
         default:     lidx = '0;
      endcase
   end

   assign addr_sum = {{(CW+1-AW){1'b0}}, head_ff} + {1'b0, lidx};
   assign phys     = (addr_sum >= DEPTH_X) ? AW'(addr_sum - DEPTH_X) : addr_sum[AW-1:0];

   // shared weight unit
   assign sum_w   = ins_ff.weight + rd_entry.weight;
   assign rd_less = rd_entry.weight < ins_ff.weight;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      internal_in = internal_ff;
      idx_in      = idx_ff;
      merge_in    = merge_ff;
      ins_in      = ins_ff;
      res_in      = res_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      wr_entry    = ins_ff;
      finish      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in.status         = htb_pkg::STATUS_OK;
               res_in.node_ref       = '0;
               res_in.node_frequency = '0;
               res_in.left_ref       = htb_pkg::REF_NONE;
               res_in.right_ref      = htb_pkg::REF_NONE;
               res_in.last           = 1'b0;
               merge_in              = 1'b0;
               state_in              = S_DONE;
               case (req_chan.action)
                  htb_pkg::ACT_ADD: begin
                     if (count_ff == DEPTH_C) begin
                        res_in.status = htb_pkg::STATUS_FULL;
                     end else begin
                        ins_in.weight = {{(htb_pkg::WEIGHT_W-htb_pkg::FREQ_W){1'b0}},
                                         req_chan.frequency};
                        ins_in.node   = {1'b0, req_chan.symbol};
                        idx_in        = count_ff;
                        state_in      = S_SHIFT_RD;
                     end
                  end
                  htb_pkg::ACT_MERGE: begin
                     if (count_ff == '0) begin
                        res_in.status = htb_pkg::STATUS_EMPTY;
                     end else if (internal_ff == htb_pkg::INTERNAL_MAX) begin
                        res_in.status = htb_pkg::STATUS_COMPLETE;
                     end else begin
                        rd_en    = 1'b1;
                        merge_in = 1'b1;
                        state_in = S_HEAD;
                     end
                  end
                  htb_pkg::ACT_CLEAR: begin
                     count_in    = '0;
                     internal_in = '0;
                     head_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_HEAD: begin
            // front entry is on the read port
            if (count_ff == CW'(1)) begin
               if (rd_entry.node[htb_pkg::REF_W-1]) begin
                  // a lone internal node is already the root
                  res_in.status = htb_pkg::STATUS_COMPLETE;
                  merge_in      = 1'b0;
                  state_in      = S_DONE;
               end else begin
                  res_in.left_ref = rd_entry.node;
                  ins_in.weight   = rd_entry.weight;
                  ins_in.node     = {1'b1, internal_ff};
                  head_in         = phys;
                  count_in        = '0;
                  idx_in          = '0;
                  state_in        = S_SHIFT_RD;
               end
            end else begin
               res_in.left_ref = rd_entry.node;
               ins_in.weight   = rd_entry.weight;
               rd_en           = 1'b1;
               state_in        = S_SECOND;
            end
         end
         S_SECOND: begin
            res_in.right_ref = rd_entry.node;
            ins_in.weight    = sum_w;
            ins_in.node      = {1'b1, internal_ff};
            head_in          = phys;
            count_in         = count_ff - CW'(2);
            idx_in           = count_ff - CW'(2);
            state_in         = S_SHIFT_RD;
         end
         S_SHIFT_RD: begin
            if (idx_ff == '0) begin
               wr_en  = 1'b1;
               finish = 1'b1;
            end else begin
               rd_en    = 1'b1;
               state_in = S_SHIFT_CMP;
            end
         end
         S_SHIFT_CMP: begin
            wr_en = 1'b1;
            if (rd_less) begin
               finish = 1'b1;
            end else begin
               // equal or heavier entry moves one place toward the tail
               wr_entry = rd_entry;
               idx_in   = idx_ff - CW'(1);
               state_in = S_SHIFT_RD;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         count_in = count_ff + CW'(1);
         state_in = S_DONE;
         if (merge_ff) begin
            internal_in           = internal_ff + htb_pkg::INT_W'(1);
            res_in.node_ref       = {1'b1, internal_ff};
            res_in.node_frequency = ins_ff.weight;
            res_in.last           = (count_ff == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         internal_ff <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         internal_ff <= internal_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      merge_ff <= merge_in;
      ins_ff   <= ins_in;
      res_ff   <= res_in;
   end

   htb_ram #(
      .WIDTH(EW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(phys),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(phys),
      .rd_data(ram_rd)
   );

   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above queue depth");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en)
      else $error("queue ram written while idle");

   a_shift_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_RD || state_ff == S_SHIFT_CMP) |->
      (idx_ff <= count_ff && count_ff < DEPTH_C))
      else $error("insert walk out of range");

   a_cmp_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_CMP) |-> (idx_ff != '0))
      else $error("compare step at queue front");

   a_internal_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=>
      (internal_ff == $past(internal_ff) || internal_ff == '0))
      else $error("node counter moved on item accept");

endmodule
